// ===== rtl/stspg_pkg.sv =====
// shared types and constants for the step/direction pulse generator
package stspg_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned PulseWidth = 16;
  localparam int unsigned CfgAddrWidth = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_DELAY = 2'd3
  } phase_e;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_DRIVE_ENABLED     = 3'd0,
    CFG_SPEED_INTERVAL_US = 3'd1,
    CFG_SPEED_FORWARD     = 3'd2,
    CFG_PULSE_WIDTH_US    = 3'd3,
    CFG_STEP_DELAY_US     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                  drive_enabled;
    logic [DataWidth-1:0]  speed_interval_us;
    logic                  speed_forward;
    logic [PulseWidth-1:0] pulse_width_us;
    logic [DataWidth-1:0]  step_delay_us;
  } cfg_t;

  typedef struct packed {
    logic                 step_level;
    logic                 dir_level;
    logic                 enable_level;
    logic                 step_started;
    logic                 move_busy;
    logic [DataWidth-1:0] position_now;
    logic [DataWidth-1:0] steps_issued;
  } res_t;

endpackage

// ===== rtl/stspg_cfg_regs.sv =====
// configuration register file with elapsed timer restart strobe
module stspg_cfg_regs
  import stspg_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [DataWidth-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o,
  output logic                    elapsed_clr_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d         = cfg_q;
    elapsed_clr_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DRIVE_ENABLED: cfg_d.drive_enabled = cfg_wdata_i[0];
        CFG_SPEED_INTERVAL_US: begin
          cfg_d.speed_interval_us = cfg_wdata_i;
          elapsed_clr_o           = 1'b1;
        end
        CFG_SPEED_FORWARD: cfg_d.speed_forward = cfg_wdata_i[0];
        CFG_PULSE_WIDTH_US: cfg_d.pulse_width_us = cfg_wdata_i[PulseWidth-1:0];
        CFG_STEP_DELAY_US: cfg_d.step_delay_us = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_enabled     <= 1'b0;
      cfg_q.speed_interval_us <= '0;
      cfg_q.speed_forward     <= 1'b1;
      cfg_q.pulse_width_us    <= PulseWidth'(2);
      cfg_q.step_delay_us     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/stspg_core.sv =====
// pulse phase sequencer, position and pulse counters, timers
module stspg_core
  import stspg_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 elapsed_clr_i,
  input  logic                 proc_i,
  input  logic                 kind_i,
  input  logic [DataWidth-1:0] move_steps_i,
  output res_t                 res_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > DataWidth) ? COUNT_WIDTH : DataWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] ticks_q, ticks_d;
  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [DataWidth-1:0]   left_q, left_d;
  logic [DataWidth-1:0]   pos_q, pos_d;
  logic [DataWidth-1:0]   total_q, total_d;
  logic                   dir_q, dir_d;
  logic                   move_q, move_d;
  logic                   start;
  logic                   neg;
  logic [DataWidth-1:0]   mag;
  logic [PulseWidth-1:0]  width;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CntMax) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                   input logic [DataWidth-1:0]   lim);
    return (CmpWidth'(cnt) >= CmpWidth'(lim)) || (cnt == CntMax);
  endfunction

  assign width = (cfg_i.pulse_width_us == '0) ? PulseWidth'(1) : cfg_i.pulse_width_us;
  assign neg   = move_steps_i[DataWidth-1];
  assign mag   = neg ? (DataWidth'(0) - move_steps_i) : move_steps_i;

  // next state
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    elapsed_d = elapsed_q;
    left_d    = left_q;
    pos_d     = pos_q;
    total_d   = total_q;
    dir_d     = dir_q;
    move_d    = move_q;
    start     = 1'b0;
    if (proc_i) begin
      if (kind_i) begin
        if (phase_q == PH_IDLE && move_steps_i != '0) begin
          dir_d = !neg;
          if (cfg_i.drive_enabled) begin
            move_d = 1'b1;
            left_d = mag - DataWidth'(1);
            start  = 1'b1;
          end
        end
      end else begin
        elapsed_d = sat_inc(elapsed_q);
        case (phase_q)
          PH_HIGH: begin
            ticks_d = sat_inc(ticks_q);
            if (reached(ticks_d, DataWidth'(width))) begin
              phase_d = PH_LOW;
              ticks_d = '0;
            end
          end
          PH_LOW, PH_DELAY: begin
            ticks_d = sat_inc(ticks_q);
            if ((phase_q == PH_LOW && reached(ticks_d, DataWidth'(width))) ||
                (phase_q == PH_DELAY && reached(ticks_d, cfg_i.step_delay_us))) begin
              ticks_d = '0;
              if (phase_q == PH_LOW && move_q && cfg_i.step_delay_us != '0) begin
                phase_d = PH_DELAY;
              end else if (move_q && left_q != '0 && cfg_i.drive_enabled) begin
                left_d = left_q - DataWidth'(1);
                start  = 1'b1;
              end else begin
                phase_d = PH_IDLE;
                move_d  = 1'b0;
                left_d  = '0;
              end
            end
          end
          default: begin
            if (cfg_i.drive_enabled && cfg_i.speed_interval_us != '0) begin
              dir_d = cfg_i.speed_forward;
              if (reached(elapsed_d, cfg_i.speed_interval_us)) begin
                elapsed_d = '0;
                move_d    = 1'b0;
                left_d    = '0;
                start     = 1'b1;
              end
            end
          end
        endcase
      end
      if (start) begin
        phase_d = PH_HIGH;
        ticks_d = '0;
        total_d = total_q + DataWidth'(1);
        pos_d   = dir_d ? pos_q + DataWidth'(1) : pos_q - DataWidth'(1);
      end
    end
    if (elapsed_clr_i) begin
      elapsed_d = '0;
    end
  end

  // result fields after the item is applied
  always_comb begin
    res_o.step_level   = (phase_d == PH_HIGH);
    res_o.dir_level    = dir_d;
    res_o.enable_level = !cfg_i.drive_enabled;
    res_o.step_started = start;
    res_o.move_busy    = (phase_d != PH_IDLE);
    res_o.position_now = pos_d;
    res_o.steps_issued = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ticks_q   <= '0;
      elapsed_q <= '0;
      left_q    <= '0;
      pos_q     <= '0;
      total_q   <= '0;
      dir_q     <= 1'b0;
      move_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      elapsed_q <= elapsed_d;
      left_q    <= left_d;
      pos_q     <= pos_d;
      total_q   <= total_d;
      dir_q     <= dir_d;
      move_q    <= move_d;
    end
  end

  a_start_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && start |=> phase_q == PH_HIGH)
    else $error("pulse start did not enter high phase");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !move_q && left_q == '0)
    else $error("idle with move state left over");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q == $past(total_q) || total_q == $past(total_q) + DataWidth'(1))
    else $error("pulse total jumped");

  a_pos_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == $past(total_q) |-> pos_q == $past(pos_q))
    else $error("position moved without a pulse");

endmodule

// ===== rtl/stepper_step_pulse_generator_core.sv =====
// top level: input register, pulse sequencer, result register, config port
// Takes one item (tick or move request) per clock while the output is not stalled; each result
// is presented once the item has passed the input register and the single-pass state update
// into the result register. The input register holds its item only while a result is held
// with out_ready_i low, and a new transfer is refused only when that held item is present, so
// the sustained rate is one item per cycle when out_ready_i stays high. Configuration writes
// take effect at the next edge and must be made while idle; the block does not enforce this.
module stepper_step_pulse_generator_core
  import stspg_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgAddrWidth-1:0]     cfg_addr_i,
  input  logic [DataWidth-1:0]        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic signed [DataWidth-1:0] move_steps_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        step_level_o,
  output logic                        dir_level_o,
  output logic                        enable_level_o,
  output logic                        step_started_o,
  output logic                        move_busy_o,
  output logic signed [DataWidth-1:0] position_now_o,
  output logic [DataWidth-1:0]        steps_issued_o
);

  cfg_t                 cfg;
  logic                 elapsed_clr;
  logic                 s1_valid_q, s1_valid_d;
  logic                 kind_q;
  logic [DataWidth-1:0] steps_q;
  logic                 out_valid_q, out_valid_d;
  res_t                 res;
  res_t                 res_q;
  logic                 adv;
  logic                 in_fire;

  stspg_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .cfg_o         (cfg),
    .elapsed_clr_o (elapsed_clr)
  );

  stspg_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg),
    .elapsed_clr_i (elapsed_clr),
    .proc_i        (adv),
    .kind_i        (kind_q),
    .move_steps_i  (steps_q),
    .res_o         (res)
  );

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_i;
      steps_q <= move_steps_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign step_level_o   = res_q.step_level;
  assign dir_level_o    = res_q.dir_level;
  assign enable_level_o = res_q.enable_level;
  assign step_started_o = res_q.step_started;
  assign move_busy_o    = res_q.move_busy;
  assign position_now_o = res_q.position_now;
  assign steps_issued_o = res_q.steps_issued;

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && out_valid_q)
    else $error("item dropped during output stall");

endmodule

// ===== test/stspg_step_checker.sv =====
// checker for the step pulse generator core: predicts each result and compares it
`timescale 1ns / 100ps

module stspg_step_checker
  import stspg_pkg::*;
#(
  parameter int unsigned CountWidth = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [DataWidth-1:0]    cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    kind_i,
  input  logic [DataWidth-1:0]    move_steps_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  res_t                    result_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output int unsigned             pulses_o
);

  typedef logic [CountWidth-1:0] count_t;
  localparam count_t CountMax = '1;

  cfg_t                 regs;
  logic [DataWidth-1:0] pos;
  logic [DataWidth-1:0] total;
  logic [DataWidth-1:0] left;
  logic                 fwd;
  logic                 in_move;
  logic                 began;
  phase_e               ph;
  count_t               ph_ticks;
  count_t               since_step;
  res_t                 want_q[$];
  int unsigned          n_checked;

  function automatic count_t bump(input count_t v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  function automatic logic hit(input count_t v, input logic [DataWidth-1:0] lim);
    return (v >= lim) || (v == CountMax);
  endfunction

  function automatic void begin_pulse();
    ph       = PH_HIGH;
    ph_ticks = '0;
    total    = total + 1'b1;
    pos      = fwd ? pos + 1'b1 : pos - 1'b1;
    began    = 1'b1;
  endfunction

  function automatic void end_or_next();
    if (in_move && left != '0 && regs.drive_enabled) begin
      left = left - 1'b1;
      begin_pulse();
    end else begin
      ph       = PH_IDLE;
      ph_ticks = '0;
      in_move  = 1'b0;
      left     = '0;
    end
  endfunction

  function automatic res_t advance(input logic is_move, input logic [DataWidth-1:0] steps);
    logic [DataWidth-1:0] width;
    res_t                 r;
    width = (regs.pulse_width_us == '0) ? DataWidth'(1) : DataWidth'(regs.pulse_width_us);
    began = 1'b0;
    if (is_move) begin
      if (ph == PH_IDLE && steps != '0) begin
        fwd = ~steps[DataWidth-1];
        if (regs.drive_enabled) begin
          in_move = 1'b1;
          left    = (steps[DataWidth-1] ? -steps : steps) - 1'b1;
          begin_pulse();
        end
      end
    end else begin
      since_step = bump(since_step);
      case (ph)
        PH_HIGH: begin
          ph_ticks = bump(ph_ticks);
          if (hit(ph_ticks, width)) begin
            ph       = PH_LOW;
            ph_ticks = '0;
          end
        end
        PH_LOW: begin
          ph_ticks = bump(ph_ticks);
          if (hit(ph_ticks, width)) begin
            ph_ticks = '0;
            if (in_move && regs.step_delay_us != '0) begin
              ph = PH_DELAY;
            end else begin
              end_or_next();
            end
          end
        end
        PH_DELAY: begin
          ph_ticks = bump(ph_ticks);
          if (hit(ph_ticks, regs.step_delay_us)) begin
            ph_ticks = '0;
            end_or_next();
          end
        end
        default: begin
          if (regs.drive_enabled && regs.speed_interval_us != '0) begin
            fwd = regs.speed_forward;
            if (hit(since_step, regs.speed_interval_us)) begin
              since_step = '0;
              in_move    = 1'b0;
              left       = '0;
              begin_pulse();
            end
          end
        end
      endcase
    end
    r.step_level   = (ph == PH_HIGH);
    r.dir_level    = fwd;
    r.enable_level = ~regs.drive_enabled;
    r.step_started = began;
    r.move_busy    = (ph != PH_IDLE);
    r.position_now = pos;
    r.steps_issued = total;
    return r;
  endfunction

  task automatic flag(input string msg);
    if (fail_count_o < 30) begin
      $display("checker: %s", msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [DataWidth-1:0] got,
                             input logic [DataWidth-1:0] exp);
    if (got !== exp) begin
      flag($sformatf("result %0d: %s is %h, expected %h", n_checked, name, got, exp));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      regs         = '{drive_enabled: 1'b0, speed_interval_us: '0, speed_forward: 1'b1,
                       pulse_width_us: 16'd2, step_delay_us: '0};
      pos          = '0;
      total        = '0;
      left         = '0;
      fwd          = 1'b0;
      in_move      = 1'b0;
      began        = 1'b0;
      ph           = PH_IDLE;
      ph_ticks     = '0;
      since_step   = '0;
      want_q.delete();
      n_checked    = 0;
      fail_count_o = 0;
      pulses_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          flag($sformatf("result %0d arrived with nothing expected", n_checked));
        end else begin
          want = want_q.pop_front();
          check_field("step_level", result_i.step_level, want.step_level);
          check_field("dir_level", result_i.dir_level, want.dir_level);
          check_field("enable_level", result_i.enable_level, want.enable_level);
          check_field("step_started", result_i.step_started, want.step_started);
          check_field("move_busy", result_i.move_busy, want.move_busy);
          check_field("position_now", result_i.position_now, want.position_now);
          check_field("steps_issued", result_i.steps_issued, want.steps_issued);
          if (want.step_started) begin
            pulses_o++;
          end
        end
        n_checked++;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_DRIVE_ENABLED:     regs.drive_enabled = cfg_wdata_i[0];
          CFG_SPEED_INTERVAL_US: begin
            regs.speed_interval_us = cfg_wdata_i;
            since_step             = '0;
          end
          CFG_SPEED_FORWARD:     regs.speed_forward = cfg_wdata_i[0];
          CFG_PULSE_WIDTH_US:    regs.pulse_width_us = cfg_wdata_i[PulseWidth-1:0];
          CFG_STEP_DELAY_US:     regs.step_delay_us = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        want_q.push_back(advance(kind_i, move_steps_i));
      end
    end
    pending_o = want_q.size();
  end

endmodule

// ===== test/tb_stepper_step_pulse_generator_core.sv =====
// testbench top for the step pulse generator core: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_stepper_step_pulse_generator_core;
  import stspg_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned Phases     = 18;
  localparam int unsigned PhaseItems = 62;
  localparam logic        KindTick   = 1'b0;
  localparam logic        KindMove   = 1'b1;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic [CfgAddrWidth-1:0]     cfg_addr_i   = '0;
  logic [DataWidth-1:0]        cfg_wdata_i  = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic                        kind_i       = 1'b0;
  logic signed [DataWidth-1:0] move_steps_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic                        step_level_o;
  logic                        dir_level_o;
  logic                        enable_level_o;
  logic                        step_started_o;
  logic                        move_busy_o;
  logic signed [DataWidth-1:0] position_now_o;
  logic [DataWidth-1:0]        steps_issued_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pulses;
  int unsigned tx_pct      = 0;
  int unsigned rx_pct      = 0;
  int unsigned hold_asked  = 0;
  int unsigned hold_served = 0;
  int unsigned quiet       = 0;
  int unsigned n_items     = 0;
  int unsigned n_moves     = 0;
  int unsigned n_settings  = 0;
  cfg_t        shadow      = '{drive_enabled: 1'b0, speed_interval_us: '0, speed_forward: 1'b1,
                               pulse_width_us: 16'd2, step_delay_us: '0};

  always #2 clk_i = ~clk_i;

  stepper_step_pulse_generator_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .move_steps_i,
    .out_valid_o,
    .out_ready_i,
    .step_level_o,
    .dir_level_o,
    .enable_level_o,
    .step_started_o,
    .move_busy_o,
    .position_now_o,
    .steps_issued_o
  );

  stspg_step_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .kind_i,
    .move_steps_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .result_i     ({step_level_o, dir_level_o, enable_level_o, step_started_o, move_busy_o,
                    position_now_o, steps_issued_o}),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pulses_o     (pulses)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("tb_stepper_step_pulse_generator_core: FAIL");
        $finish;
      end
    end
  end

  // receiver side: random stalls plus the requested long hold-off
  initial begin : receiver
    int unsigned k;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_served) begin
        out_ready_i <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(posedge clk_i);
        hold_served++;
      end
      out_ready_i <= (rx_pct == 0) || ($urandom_range(0, 99) >= rx_pct);
    end
  end

  task automatic push_item(input logic is_move, input logic [DataWidth-1:0] steps);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= is_move;
    move_steps_i <= steps;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    if (is_move) begin
      n_moves++;
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // writes changed registers, all of them when asked, and now and then an unchanged one
  task automatic apply_cfg(input cfg_t c, input logic every);
    if (every || c.drive_enabled != shadow.drive_enabled || $urandom_range(0, 3) == 0) begin
      write_reg(CFG_DRIVE_ENABLED, DataWidth'(c.drive_enabled));
    end
    if (every || c.speed_interval_us != shadow.speed_interval_us
        || $urandom_range(0, 3) == 0) begin
      write_reg(CFG_SPEED_INTERVAL_US, c.speed_interval_us);
    end
    if (every || c.speed_forward != shadow.speed_forward || $urandom_range(0, 3) == 0) begin
      write_reg(CFG_SPEED_FORWARD, DataWidth'(c.speed_forward));
    end
    if (every || c.pulse_width_us != shadow.pulse_width_us || $urandom_range(0, 3) == 0) begin
      write_reg(CFG_PULSE_WIDTH_US, DataWidth'(c.pulse_width_us));
    end
    if (every || c.step_delay_us != shadow.step_delay_us || $urandom_range(0, 3) == 0) begin
      write_reg(CFG_STEP_DELAY_US, c.step_delay_us);
    end
    cfg_we_i <= 1'b0;
    shadow = c;
    n_settings++;
  endtask

  initial begin : stimulus
    cfg_t                 c;
    logic [DataWidth-1:0] steps;
    int unsigned          p;
    int unsigned          n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    c = shadow;
    @(posedge clk_i);

    // drive off: moves only set the direction, zero move does nothing
    push_item(KindMove, 32'd3);
    push_item(KindTick, $urandom());
    push_item(KindMove, '0);
    push_item(KindMove, '1);
    settle();

    // zero pulse width, two-step move with a move arriving while busy
    c.drive_enabled  = 1'b1;
    c.pulse_width_us = '0;
    apply_cfg(c, 1'b0);
    push_item(KindMove, 32'd2);
    push_item(KindMove, -32'sd7);
    repeat (4) push_item(KindTick, $urandom());
    settle();

    // step delay after a single reverse step
    c.pulse_width_us = 16'd1;
    c.step_delay_us  = 32'd2;
    apply_cfg(c, 1'b0);
    push_item(KindMove, '1);
    repeat (4) push_item(KindTick, $urandom());
    settle();

    // most negative move with widest pulse, then dropped by disabling mid-move
    c.pulse_width_us = '1;
    c.step_delay_us  = '1;
    apply_cfg(c, 1'b0);
    push_item(KindMove, 32'h8000_0000);
    push_item(KindTick, $urandom());
    settle();
    c.drive_enabled  = 1'b0;
    c.pulse_width_us = 16'd1;
    c.step_delay_us  = '0;
    apply_cfg(c, 1'b0);
    repeat (2) push_item(KindTick, $urandom());
    settle();

    // continuous stepping in reverse
    c.drive_enabled     = 1'b1;
    c.speed_interval_us = 32'd3;
    c.speed_forward     = 1'b0;
    apply_cfg(c, 1'b1);
    repeat (5) push_item(KindTick, $urandom());
    settle();

    // longest forward move, then drive off
    c.speed_interval_us = '1;
    c.speed_forward     = 1'b1;
    apply_cfg(c, 1'b0);
    push_item(KindMove, 32'h7FFF_FFFF);
    push_item(KindTick, $urandom());
    settle();
    c.drive_enabled = 1'b0;
    apply_cfg(c, 1'b0);
    repeat (2) push_item(KindTick, $urandom());

    for (p = 0; p < Phases; p++) begin
      settle();
      tx_pct = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 36 : 0;
      rx_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 36 : 0;
      c.drive_enabled = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       c.speed_interval_us = '0;
        1:       c.speed_interval_us = '1;
        2:       c.speed_interval_us = $urandom();
        default: c.speed_interval_us = $urandom_range(1, 12);
      endcase
      c.speed_forward = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 15))
        0:       c.pulse_width_us = '0;
        1:       c.pulse_width_us = '1;
        default: c.pulse_width_us = PulseWidth'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 15))
        0:       c.step_delay_us = '1;
        1:       c.step_delay_us = $urandom();
        default: c.step_delay_us = $urandom_range(0, 5);
      endcase
      apply_cfg(c, p == 0);
      if (p == 4) begin
        hold_asked++;
      end
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 9) == 0) begin
            steps = $urandom();
          end else begin
            steps = DataWidth'(int'($urandom_range(0, 12)) - 6);
          end
          push_item(KindMove, steps);
        end else begin
          push_item(KindTick, $urandom());
        end
      end
    end
    settle();

    $display("run: %0d items (%0d move requests) under %0d register settings",
             n_items, n_moves, n_settings);
    $display("run: %0d step pulses checked, %0d long receiver hold-offs", pulses, hold_served);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_stepper_step_pulse_generator_core: PASS");
    end else begin
      $display("tb_stepper_step_pulse_generator_core: FAIL");
    end
    $finish;
  end

endmodule
